FILE: design/foc_pkg.sv
// Package: word types, register indexes and sine table helpers for the dq-to-PWM modulator.
package foc_pkg;

    localparam int TRIG_ENTRIES_DEFAULT = 256;

    localparam longint unsigned PI_Q30 = 64'd3373259426;
    localparam logic signed [15:0] SIN60_Q15 = 16'sd28377;
    localparam logic [15:0] DUTY_CENTER_RESET = 16'd500;

    localparam logic [2:0] REG_SUPPLY = 3'd0;
    localparam logic [2:0] REG_LIMIT  = 3'd1;
    localparam logic [2:0] REG_SCALE  = 3'd2;
    localparam logic [2:0] REG_MODE   = 3'd3;
    localparam logic [2:0] REG_CENTER = 3'd4;

    localparam logic MODE_SINE  = 1'b0;
    localparam logic MODE_SVPWM = 1'b1;

    localparam longint unsigned TAYLOR_DIV [1:7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                     64'd110, 64'd156, 64'd210};

    typedef struct packed {
        logic signed [15:0] volt_q;
        logic signed [15:0] volt_d;
        logic signed [15:0] elec_angle;
    } in_word_t;

    typedef struct packed {
        logic [15:0] duty_a;
        logic [15:0] duty_b;
        logic [15:0] duty_c;
    } out_word_t;

    function automatic logic signed [15:0] trig_poly(longint unsigned x);
        longint unsigned term;
        longint          sum;
        longint unsigned r;
        term = x;
        sum  = longint'(x);
        for (int k = 1; k <= 7; k++)
        begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / TAYLOR_DIV[k];
            if ((k & 1) == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        r = (longint'(sum) * 64'd32767 + 64'd536870912) >> 30;
        return r[15:0];
    endfunction

endpackage

FILE: design/foc_dq_to_pwm_modulator.sv
// Top level: pipelined inverse Park/Clarke transform with vector limit and PWM duty generation.
//
// Takes one dq voltage word per clock, unless the output stalls, and returns three phase
// compare values; throughput is one word per cycle while not stalled. The pipeline holds the
// vector limit path: an 8-stage square root pipeline (two root bits per stage) followed by an
// 8-stage restoring divider (two quotient bits per stage), then eight multiply and add stages
// for the transforms and duty scaling. A stall on a held output word freezes the whole pipeline.
// Configuration writes are always ready and must be issued while the pipeline is empty.
module foc_dq_to_pwm_modulator #(
    parameter int TRIG_TABLE_ENTRIES = foc_pkg::TRIG_ENTRIES_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  foc_pkg::in_word_t   in_word,
    output logic                out_valid,
    input  logic                out_stall,
    output foc_pkg::out_word_t  out_word,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [25:0]         cfg_data
);

    localparam int IW = $clog2(TRIG_TABLE_ENTRIES);

    typedef struct packed {
        logic signed [15:0] q;
        logic signed [15:0] d;
        logic signed [15:0] st;
        logic signed [15:0] ct;
        logic               over;
    } carry_t;

    logic [14:0] supply_reg;
    logic [14:0] limit_reg;
    logic [25:0] scale_reg;
    logic        mode_reg;
    logic [15:0] center_reg;

    logic adv;

    logic signed [15:0] sin_rom [TRIG_TABLE_ENTRIES];

    for (genvar gi = 0; gi < TRIG_TABLE_ENTRIES; gi++)
    begin : g_rom
        localparam longint unsigned X =
            (longint'(2 * gi + 1) * foc_pkg::PI_Q30) / longint'(4 * TRIG_TABLE_ENTRIES);
        assign sin_rom[gi] = foc_pkg::trig_poly(X);
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            supply_reg <= '0;
            limit_reg  <= '0;
            scale_reg  <= '0;
            mode_reg   <= foc_pkg::MODE_SVPWM;
            center_reg <= foc_pkg::DUTY_CENTER_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                foc_pkg::REG_SUPPLY: supply_reg <= cfg_data[14:0];
                foc_pkg::REG_LIMIT:  limit_reg  <= cfg_data[14:0];
                foc_pkg::REG_SCALE:  scale_reg  <= cfg_data;
                foc_pkg::REG_MODE:   mode_reg   <= cfg_data[0];
                foc_pkg::REG_CENTER: center_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    logic out_valid_reg;
    foc_pkg::out_word_t out_word_reg;

    assign adv       = !out_valid_reg || !out_stall;
    assign in_stall  = !adv;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // stage A: capture input
    logic a_v_reg;
    foc_pkg::in_word_t a_w_reg;

    // stage B: squares and table lookup
    logic b_v_reg;
    logic [31:0] b_qq_reg;
    logic [31:0] b_dd_reg;
    logic [29:0] b_lim_reg;
    logic signed [15:0] b_q_reg;
    logic signed [15:0] b_d_reg;
    logic signed [15:0] b_st_reg;
    logic signed [15:0] b_ct_reg;

    logic [31:0]   pos_full;
    logic [IW-1:0] pos;
    logic [1:0]    quad_s;
    logic [1:0]    quad_c;
    logic signed [15:0] st_v;
    logic signed [15:0] ct_v;

    assign pos_full = 32'(a_w_reg.elec_angle[13:0]) * 32'(TRIG_TABLE_ENTRIES);
    assign pos      = pos_full[IW+13:14];
    assign quad_s   = a_w_reg.elec_angle[15:14];
    assign quad_c   = quad_s + 2'd1;

    always_comb
    begin
        st_v = quad_s[0] ? sin_rom[IW'(TRIG_TABLE_ENTRIES - 1) - pos] : sin_rom[pos];
        ct_v = quad_c[0] ? sin_rom[IW'(TRIG_TABLE_ENTRIES - 1) - pos] : sin_rom[pos];
        if (quad_s[1])
            st_v = -st_v;
        if (quad_c[1])
            ct_v = -ct_v;
    end

    // square root and divider pipelines
    logic        sq_v_reg   [0:8];
    carry_t      sq_c_reg   [0:8];
    logic [31:0] sq_rem_reg [0:8];
    logic [31:0] sq_acc_reg [0:8];

    logic        dv_v_reg   [0:8];
    carry_t      dv_c_reg   [0:8];
    logic [15:0] dv_rem_reg [0:8];
    logic [15:0] dv_quo_reg [0:8];
    logic [15:0] dv_m_reg   [0:8];

    logic [15:0] dividend_lo;
    assign dividend_lo = {limit_reg[0], 15'd0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg     <= 1'b0;
            b_v_reg     <= 1'b0;
            sq_v_reg[0] <= 1'b0;
            dv_v_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            a_v_reg     <= in_valid;
            b_v_reg     <= a_v_reg;
            sq_v_reg[0] <= b_v_reg;
            dv_v_reg[0] <= sq_v_reg[8];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_w_reg   <= in_word;
            b_qq_reg  <= 32'(a_w_reg.volt_q) * 32'(a_w_reg.volt_q);
            b_dd_reg  <= 32'(a_w_reg.volt_d) * 32'(a_w_reg.volt_d);
            b_lim_reg <= 30'(limit_reg) * 30'(limit_reg);
            b_q_reg   <= a_w_reg.volt_q;
            b_d_reg   <= a_w_reg.volt_d;
            b_st_reg  <= st_v;
            b_ct_reg  <= ct_v;

            sq_rem_reg[0]     <= b_qq_reg + b_dd_reg;
            sq_acc_reg[0]     <= '0;
            sq_c_reg[0].q     <= b_q_reg;
            sq_c_reg[0].d     <= b_d_reg;
            sq_c_reg[0].st    <= b_st_reg;
            sq_c_reg[0].ct    <= b_ct_reg;
            sq_c_reg[0].over  <= (33'(b_qq_reg) + 33'(b_dd_reg)) > 33'(b_lim_reg);

            dv_c_reg[0]   <= sq_c_reg[8];
            dv_m_reg[0]   <= sq_acc_reg[8][15:0];
            dv_rem_reg[0] <= {2'd0, limit_reg[14:1]};
            dv_quo_reg[0] <= '0;
        end
    end

    for (genvar g = 0; g < 8; g++)
    begin : g_sqrt
        logic [31:0] rem_next;
        logic [31:0] acc_next;
        logic [31:0] bv;

        always_comb
        begin
            rem_next = sq_rem_reg[g];
            acc_next = sq_acc_reg[g];
            bv       = '0;
            for (int s = 0; s < 2; s++)
            begin
                bv = 32'd1 << (30 - 4 * g - 2 * s);
                if (rem_next >= acc_next + bv)
                begin
                    rem_next = rem_next - (acc_next + bv);
                    acc_next = acc_next + (bv << 1);
                end
                acc_next = acc_next >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_v_reg[g+1] <= 1'b0;
            else if (adv)
                sq_v_reg[g+1] <= sq_v_reg[g];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_rem_reg[g+1] <= rem_next;
                sq_acc_reg[g+1] <= acc_next;
                sq_c_reg[g+1]   <= sq_c_reg[g];
            end
        end
    end

    for (genvar g = 0; g < 8; g++)
    begin : g_div
        logic [16:0] part;
        logic [15:0] rem_next;
        logic [15:0] quo_next;

        always_comb
        begin
            rem_next = dv_rem_reg[g];
            quo_next = dv_quo_reg[g];
            part     = '0;
            for (int s = 0; s < 2; s++)
            begin
                part = {rem_next, dividend_lo[15 - 2 * g - s]};
                if (part >= {1'b0, dv_m_reg[g]})
                begin
                    part     = part - {1'b0, dv_m_reg[g]};
                    quo_next = {quo_next[14:0], 1'b1};
                end
                else
                    quo_next = {quo_next[14:0], 1'b0};
                rem_next = part[15:0];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_v_reg[g+1] <= 1'b0;
            else if (adv)
                dv_v_reg[g+1] <= dv_v_reg[g];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_rem_reg[g+1] <= rem_next;
                dv_quo_reg[g+1] <= quo_next;
                dv_m_reg[g+1]   <= dv_m_reg[g];
                dv_c_reg[g+1]   <= dv_c_reg[g];
            end
        end
    end

    // transform and duty stages
    logic m1_v_reg, m2_v_reg, m3_v_reg, m4_v_reg, m5_v_reg, m6_v_reg, m7_v_reg;
    logic signed [32:0] m1_qs_reg, m1_ds_reg;
    logic signed [15:0] m1_st_reg, m1_ct_reg;
    logic signed [31:0] m2_dc_reg, m2_qs_reg, m2_ds_reg, m2_qc_reg;
    logic signed [17:0] m3_alpha_reg, m3_beta_reg;
    logic signed [17:0] m4_alpha_reg;
    logic signed [16:0] m4_half_reg;
    logic signed [33:0] m4_hp_reg;
    logic signed [19:0] m5_ph_reg [3];
    logic signed [21:0] m6_x_reg  [3];
    logic signed [48:0] m7_p_reg  [3];

    logic signed [16:0] scale_v;
    logic signed [15:0] q2, d2;
    logic signed [32:0] alpha_full, beta_full;
    logic signed [18:0] tmp_v;
    logic signed [21:0] x_next [3];
    logic signed [20:0] hl_sum;
    logic signed [21:0] zero_v;
    logic signed [19:0] hi_v, lo_v;
    logic signed [20:0] u_v;

    assign scale_v    = dv_c_reg[8].over ? $signed({1'b0, dv_quo_reg[8]}) : 17'sd32768;
    assign q2         = m1_qs_reg[30:15];
    assign d2         = m1_ds_reg[30:15];
    assign alpha_full = 33'(m2_dc_reg) - 33'(m2_qs_reg);
    assign beta_full  = 33'(m2_ds_reg) + 33'(m2_qc_reg);
    assign tmp_v      = m4_hp_reg[33:15];

    always_comb
    begin
        hi_v = m5_ph_reg[0];
        lo_v = m5_ph_reg[0];
        for (int j = 1; j < 3; j++)
        begin
            if (m5_ph_reg[j] < lo_v)
                lo_v = m5_ph_reg[j];
            if (m5_ph_reg[j] > hi_v)
                hi_v = m5_ph_reg[j];
        end
        hl_sum = 21'(hi_v) + 21'(lo_v);
        zero_v = (-22'(hl_sum)) >>> 1;
        u_v    = '0;
        for (int j = 0; j < 3; j++)
        begin
            if (mode_reg == foc_pkg::MODE_SINE)
            begin
                u_v = 21'(m5_ph_reg[j]) + $signed({7'd0, supply_reg[14:1]});
                if (u_v < 0)
                    u_v = '0;
                if (u_v > $signed({6'd0, supply_reg}))
                    u_v = $signed({6'd0, supply_reg});
                x_next[j] = 22'(u_v);
            end
            else
                x_next[j] = 22'(m5_ph_reg[j]) + zero_v;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_v_reg      <= 1'b0;
            m2_v_reg      <= 1'b0;
            m3_v_reg      <= 1'b0;
            m4_v_reg      <= 1'b0;
            m5_v_reg      <= 1'b0;
            m6_v_reg      <= 1'b0;
            m7_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m1_v_reg      <= dv_v_reg[8];
            m2_v_reg      <= m1_v_reg;
            m3_v_reg      <= m2_v_reg;
            m4_v_reg      <= m3_v_reg;
            m5_v_reg      <= m4_v_reg;
            m6_v_reg      <= m5_v_reg;
            m7_v_reg      <= m6_v_reg;
            out_valid_reg <= m7_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m1_qs_reg <= 33'(dv_c_reg[8].q) * 33'(scale_v);
            m1_ds_reg <= 33'(dv_c_reg[8].d) * 33'(scale_v);
            m1_st_reg <= dv_c_reg[8].st;
            m1_ct_reg <= dv_c_reg[8].ct;

            m2_dc_reg <= 32'(d2) * 32'(m1_ct_reg);
            m2_qs_reg <= 32'(q2) * 32'(m1_st_reg);
            m2_ds_reg <= 32'(d2) * 32'(m1_st_reg);
            m2_qc_reg <= 32'(q2) * 32'(m1_ct_reg);

            m3_alpha_reg <= alpha_full[32:15];
            m3_beta_reg  <= beta_full[32:15];

            m4_alpha_reg <= m3_alpha_reg;
            m4_half_reg  <= m3_alpha_reg[17:1];
            m4_hp_reg    <= 34'(m3_beta_reg) * 34'(foc_pkg::SIN60_Q15);

            m5_ph_reg[0] <= 20'(m4_alpha_reg);
            m5_ph_reg[1] <= -20'(m4_half_reg) + 20'(tmp_v);
            m5_ph_reg[2] <= -20'(m4_half_reg) - 20'(tmp_v);

            for (int j = 0; j < 3; j++)
            begin
                m6_x_reg[j] <= x_next[j];
                m7_p_reg[j] <= 49'(m6_x_reg[j]) * 49'($signed({1'b0, scale_reg}));
            end

            if (mode_reg == foc_pkg::MODE_SINE)
            begin
                out_word_reg.duty_a <= m7_p_reg[0][31:16];
                out_word_reg.duty_b <= m7_p_reg[1][31:16];
                out_word_reg.duty_c <= m7_p_reg[2][31:16];
            end
            else
            begin
                out_word_reg.duty_a <= center_reg + m7_p_reg[0][31:16];
                out_word_reg.duty_b <= center_reg + m7_p_reg[1][31:16];
                out_word_reg.duty_c <= center_reg + m7_p_reg[2][31:16];
            end
        end
    end

`ifndef SYNTHESIS
    a_root_floor: assert property (@(posedge clk) disable iff (!rst_n)
        sq_v_reg[8] |-> (sq_rem_reg[8] <= {sq_acc_reg[8][30:0], 1'b0}))
        else $error("square root remainder too large");

    a_scale_range: assert property (@(posedge clk) disable iff (!rst_n)
        (dv_v_reg[8] && dv_c_reg[8].over) |-> (dv_quo_reg[8] <= 16'd32768))
        else $error("limit scale above unity");

    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        (m7_v_reg && in_stall) |=> m7_v_reg)
        else $error("pipeline word lost under stall");
`endif

endmodule

FILE: bench/tb.sv
// Testbench for the dq-to-PWM modulator: directed table, then random words, checked by a predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LUT_N = 256;
    localparam int DRAIN_CYCLES = 40;
    localparam longint CYCLE_LIMIT = 1000000;
    localparam int RANDOM_WORDS = 1700;
    localparam int PHASES = 8;
    localparam int DIR_ROWS = 15;
    localparam logic [2:0] REG_UNUSED = 3'd5;

    typedef struct {
        logic signed [15:0] q;
        logic signed [15:0] d;
        logic signed [15:0] ang;
        bit                 typed;
    } stim_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    foc_pkg::in_word_t   in_word = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    foc_pkg::out_word_t  out_word;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [25:0] cfg_data = '0;

    logic signed [15:0] sine_lut [LUT_N];
    longint    sh_supply = 0;
    longint    sh_limit = 0;
    longint    sh_scale = 0;
    longint    sh_mode = 1;
    longint    sh_center = 500;
    foc_pkg::out_word_t pending_duty [$];
    bit        typed_now = 1'b0;
    bit        hold_req = 1'b0;
    int        errors = 0;
    longint    cycles = 0;

    foc_dq_to_pwm_modulator u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
        .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    function automatic void build_sine_lut();
        longint unsigned x, term;
        longint          acc;
        longint unsigned r;
        for (int i = 0; i < LUT_N; i++)
        begin
            x = ((2 * i + 1) * foc_pkg::PI_Q30) / (4 * LUT_N);
            term = x;
            acc = longint'(x);
            for (int k = 1; k <= 7; k++)
            begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = term / ((2 * k) * (2 * k + 1));
                if (k % 2 == 1)
                    acc = acc - longint'(term);
                else
                    acc = acc + longint'(term);
            end
            if (acc < 0)
                acc = 0;
            r = (longint'(acc) * 32767 + (64'd1 << 29)) >> 30;
            sine_lut[i] = r[15:0];
        end
    endfunction

    function automatic longint lut_sin(logic [15:0] a);
        logic [1:0] quad;
        int         pos;
        longint     v;
        quad = a[15:14];
        pos = int'(a[13:6]);
        v = quad[0] ? sine_lut[LUT_N - 1 - pos] : sine_lut[pos];
        return quad[1] ? -v : v;
    endfunction

    function automatic longint root_floor32(longint unsigned x);
        longint unsigned rem, acc, b;
        rem = x;
        acc = 0;
        b = 64'd1 << 30;
        while (b > rem)
            b = b >> 2;
        while (b != 0)
        begin
            if (rem >= acc + b)
            begin
                rem = rem - (acc + b);
                acc = acc + 2 * b;
            end
            acc = acc >> 1;
            b = b >> 2;
        end
        return longint'(acc);
    endfunction

    function automatic foc_pkg::out_word_t duty_model(foc_pkg::in_word_t w);
        longint    q, d, st, ct, alpha, beta, half_a, tmp, mag, scl, lo, hi, zero, u;
        longint    ph [3];
        logic [15:0] ang;
        logic [15:0] res [3];
        foc_pkg::out_word_t o;
        q = w.volt_q;
        d = w.volt_d;
        ang = w.elec_angle;
        if (q * q + d * d > sh_limit * sh_limit)
        begin
            mag = root_floor32(q * q + d * d);
            if (mag == 0)
                mag = 1;
            scl = (sh_limit << 15) / mag;
            q = (q * scl) >>> 15;
            d = (d * scl) >>> 15;
        end
        st = lut_sin(ang);
        ct = lut_sin(ang + 16'd16384);
        alpha = (d * ct - q * st) >>> 15;
        beta = (d * st + q * ct) >>> 15;
        half_a = alpha >>> 1;
        tmp = (beta * longint'(foc_pkg::SIN60_Q15)) >>> 15;
        ph[0] = alpha;
        ph[1] = -half_a + tmp;
        ph[2] = -half_a - tmp;
        if (sh_mode == longint'(foc_pkg::MODE_SINE))
        begin
            for (int j = 0; j < 3; j++)
            begin
                u = ph[j] + sh_supply / 2;
                if (u < 0)
                    u = 0;
                if (u > sh_supply)
                    u = sh_supply;
                res[j] = 16'((u * sh_scale) >> 16);
            end
        end
        else
        begin
            lo = ph[0];
            hi = ph[0];
            for (int j = 1; j < 3; j++)
            begin
                if (ph[j] < lo) lo = ph[j];
                if (ph[j] > hi) hi = ph[j];
            end
            zero = (-(hi + lo)) >>> 1;
            for (int j = 0; j < 3; j++)
                res[j] = 16'(sh_center + (((ph[j] + zero) * sh_scale) >>> 16));
        end
        o.duty_a = res[0];
        o.duty_b = res[1];
        o.duty_c = res[2];
        return o;
    endfunction

    always @(posedge clk)
    begin
        foc_pkg::out_word_t exp_w;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
        if (rst_n && in_valid && !in_stall)
        begin
            if (typed_now)
                exp_w = '{16'd500, 16'd500, 16'd500};
            else
                exp_w = duty_model(in_word);
            pending_duty.push_back(exp_w);
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_duty.size() == 0)
            begin
                $display("%0t unexpected word %h", $time, out_word);
                errors++;
            end
            else
            begin
                exp_w = pending_duty.pop_front();
                if (out_word.duty_a !== exp_w.duty_a)
                begin
                    $display("%0t duty_a exp %h got %h", $time, exp_w.duty_a, out_word.duty_a);
                    errors++;
                end
                if (out_word.duty_b !== exp_w.duty_b)
                begin
                    $display("%0t duty_b exp %h got %h", $time, exp_w.duty_b, out_word.duty_b);
                    errors++;
                end
                if (out_word.duty_c !== exp_w.duty_c)
                begin
                    $display("%0t duty_c exp %h got %h", $time, exp_w.duty_c, out_word.duty_c);
                    errors++;
                end
            end
        end
    end

    // output side: bursts of random stalls, quiet stretches, and a long hold-off on request
    initial
    begin
        int burst, pct, n;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                hold_req = 1'b0;
            end
            burst = $urandom_range(10, 80);
            pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 60);
            for (int i = 0; i < burst; i++)
            begin
                if ($urandom_range(0, 199) == 0)
                begin
                    out_stall <= 1'b1;
                    n = $urandom_range(20, 60);
                    repeat (n) @(posedge clk);
                end
                out_stall <= ($urandom_range(0, 99) < pct);
                @(posedge clk);
            end
        end
    end

    task automatic idle_gap();
        int n;
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            n = 0;
        else if (r < 95)
            n = $urandom_range(1, 3);
        else
            n = $urandom_range(10, 40);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send_word(foc_pkg::in_word_t w, bit typed);
        idle_gap();
        in_valid <= 1'b1;
        in_word <= w;
        typed_now <= typed;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_duty.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, longint val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[25:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            foc_pkg::REG_SUPPLY: sh_supply = val & 16'h7FFF;
            foc_pkg::REG_LIMIT:  sh_limit = val & 16'h7FFF;
            foc_pkg::REG_SCALE:  sh_scale = val & 26'h3FFFFFF;
            foc_pkg::REG_MODE:   sh_mode = val & 1;
            foc_pkg::REG_CENTER: sh_center = val & 16'hFFFF;
            default: ;
        endcase
        @(posedge clk);
    endtask

    function automatic logic signed [15:0] pick_volt(int lim);
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return 16'($urandom);
        else if (r < 7)
            return 16'($urandom_range(0, lim / 2 + 1) - lim / 4);
        else if (r == 7)
            return ($urandom_range(0, 1) == 1) ? 16'sh7FFF : 16'sh8000;
        else
            return 16'($urandom_range(0, 4000) - 2000);
    endfunction

    stim_row_t dir_rows [DIR_ROWS] = '{
        '{16'sh7FFF, 16'sh7FFF, 16'sh0000, 1'b1},
        '{16'sh8000, 16'sh8000, 16'sh8000, 1'b1},
        '{16'sh0000, 16'sh0000, 16'sh4000, 1'b1},
        '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b1},
        '{16'sh0001, 16'shFFFF, 16'shC000, 1'b1},
        '{16'sh0000, 16'sh0000, 16'sh0000, 1'b0},
        '{16'sh7FFF, 16'sh0000, 16'sh0000, 1'b0},
        '{16'sh0000, 16'sh8000, 16'sh3FFF, 1'b0},
        '{16'sh8000, 16'sh7FFF, 16'sh8000, 1'b0},
        '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0},
        '{16'sh0000, 16'sh7FFF, 16'shBFFF, 1'b0},
        '{16'sh8000, 16'sh8000, 16'shFFFF, 1'b0},
        '{16'sh0064, 16'shFF9C, 16'sh2AAA, 1'b0},
        '{16'sh1000, 16'sh1000, 16'sh4000, 1'b0},
        '{16'shF000, 16'sh0800, 16'shC000, 1'b0}
    };

    initial
    begin
        foc_pkg::in_word_t w;
        int       per_phase;
        build_sine_lut();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (i > 0 && dir_rows[i - 1].typed && !dir_rows[i].typed)
            begin
                drain();
                write_reg(foc_pkg::REG_MODE, foc_pkg::MODE_SINE);
                write_reg(foc_pkg::REG_SUPPLY, 32767);
                write_reg(foc_pkg::REG_LIMIT, 32767);
                write_reg(foc_pkg::REG_SCALE, 65536000);
                write_reg(REG_UNUSED, 26'h3FFFFFF);
            end
            w.volt_q = dir_rows[i].q;
            w.volt_d = dir_rows[i].d;
            w.elec_angle = dir_rows[i].ang;
            send_word(w, dir_rows[i].typed);
        end
        typed_now <= 1'b0;

        per_phase = RANDOM_WORDS / PHASES;
        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            write_reg(foc_pkg::REG_MODE,
                      (p % 2 == 0) ? foc_pkg::MODE_SINE : foc_pkg::MODE_SVPWM);
            case (p)
                0:
                begin
                    write_reg(foc_pkg::REG_SUPPLY, 0);
                    write_reg(foc_pkg::REG_LIMIT, 0);
                    write_reg(foc_pkg::REG_SCALE, 65536000);
                    write_reg(foc_pkg::REG_CENTER, 65535);
                end
                1:
                begin
                    write_reg(foc_pkg::REG_SUPPLY, 32767);
                    write_reg(foc_pkg::REG_LIMIT, 32767);
                    write_reg(foc_pkg::REG_SCALE, 0);
                    write_reg(foc_pkg::REG_CENTER, 0);
                end
                2:
                begin
                    write_reg(foc_pkg::REG_SUPPLY, 32767);
                    write_reg(foc_pkg::REG_LIMIT, 0);
                    write_reg(foc_pkg::REG_SCALE, 65536000);
                    write_reg(foc_pkg::REG_CENTER, 32768);
                end
                default:
                begin
                    write_reg(foc_pkg::REG_SUPPLY, $urandom_range(0, 32767));
                    write_reg(foc_pkg::REG_LIMIT, $urandom_range(0, 32767));
                    write_reg(foc_pkg::REG_SCALE, $urandom_range(0, 65536000));
                    write_reg(foc_pkg::REG_CENTER, $urandom_range(0, 65535));
                end
            endcase
            if (p == 3)
                hold_req = 1'b1;
            for (int i = 0; i < per_phase; i++)
            begin
                w.volt_q = pick_volt(int'(sh_limit));
                w.volt_d = pick_volt(int'(sh_limit));
                w.elec_angle = 16'($urandom);
                send_word(w, 1'b0);
            end
        end

        drain();
        if (errors == 0 && pending_duty.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
